>>> hw/rtl/bfhd_pkg.sv
// ============================================================================
// bfhd_pkg
// Shared types and constants for the binary frame header decoder: status
// codes, header byte positions, register indexes and the result record.
// ============================================================================
package bfhd_pkg;

    localparam int HEADER_BYTES = 8;
    localparam int POS_W        = 4;
    localparam int LEN_W        = 32;
    localparam int SEEN_W       = LEN_W + 1;

    // Header byte positions
    localparam logic [POS_W-1:0] POS_MAGIC0  = 4'd0;
    localparam logic [POS_W-1:0] POS_MAGIC1  = 4'd1;
    localparam logic [POS_W-1:0] POS_VERSION = 4'd2;
    localparam logic [POS_W-1:0] POS_TYPE    = 4'd3;
    localparam logic [POS_W-1:0] POS_LEN_END = 4'(HEADER_BYTES - 1);
    localparam logic [POS_W-1:0] POS_DONE    = 4'(HEADER_BYTES);

    // Valid message type range
    localparam logic [7:0] TYPE_MIN = 8'h01;
    localparam logic [7:0] TYPE_MAX = 8'h08;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_MAGIC_FIRST  = 2'd0;
    localparam logic [1:0] REG_MAGIC_SECOND = 2'd1;
    localparam logic [1:0] REG_VERSION      = 2'd2;
    localparam logic [1:0] REG_MAX_LENGTH   = 2'd3;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SHORT   = 3'd1,
        ST_MAGIC   = 3'd2,
        ST_VERSION = 3'd3,
        ST_TYPE    = 3'd4,
        ST_LENGTH  = 3'd5
    } t_status;

    typedef struct packed {
        logic [7:0]       magic_first;
        logic [7:0]       magic_second;
        logic [7:0]       expected_version;
        logic [LEN_W-1:0] max_payload_length;
    } t_cfg;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             is_status;
        t_status          status_code;
        logic [7:0]       message_type;
        logic [LEN_W-1:0] payload_length;
        logic             run_last;
    } t_result;

endpackage

>>> hw/rtl/bfhd_parser.sv
// ============================================================================
// bfhd_parser
// Per-buffer frame state and the combinational step that turns one byte into
// at most two result records (payload byte, end-of-buffer status).
// ============================================================================
module bfhd_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [7:0]         i_byte,
    input  logic               i_eob,
    input  bfhd_pkg::t_cfg     i_cfg,
    output bfhd_pkg::t_result  o_res0,
    output bfhd_pkg::t_result  o_res1,
    output logic [1:0]         o_nres
);

    logic [bfhd_pkg::POS_W-1:0]  r_pos,  n_pos;
    logic [bfhd_pkg::LEN_W-1:0]  r_len,  n_len;
    logic [7:0]                  r_type, n_type;
    bfhd_pkg::t_status           r_err,  n_err;
    logic [bfhd_pkg::SEEN_W-1:0] r_seen, n_seen;

    always_comb begin
        logic              pass;
        bfhd_pkg::t_status code;
        bfhd_pkg::t_result pay;
        bfhd_pkg::t_result sts;

        n_pos  = r_pos;
        n_len  = r_len;
        n_type = r_type;
        n_err  = r_err;
        n_seen = r_seen;
        pass   = 1'b0;

        if (r_pos < bfhd_pkg::POS_DONE) begin
            unique case (r_pos)
                bfhd_pkg::POS_MAGIC0: begin
                    if (i_byte != i_cfg.magic_first && r_err == bfhd_pkg::ST_OK)
                        n_err = bfhd_pkg::ST_MAGIC;
                end
                bfhd_pkg::POS_MAGIC1: begin
                    if (i_byte != i_cfg.magic_second && r_err == bfhd_pkg::ST_OK)
                        n_err = bfhd_pkg::ST_MAGIC;
                end
                bfhd_pkg::POS_VERSION: begin
                    if (i_byte != i_cfg.expected_version && r_err == bfhd_pkg::ST_OK)
                        n_err = bfhd_pkg::ST_VERSION;
                end
                bfhd_pkg::POS_TYPE: begin
                    n_type = i_byte;
                    if ((i_byte < bfhd_pkg::TYPE_MIN || i_byte > bfhd_pkg::TYPE_MAX)
                        && r_err == bfhd_pkg::ST_OK)
                        n_err = bfhd_pkg::ST_TYPE;
                end
                default: begin
                    // Length bytes, big-endian
                    n_len = {r_len[bfhd_pkg::LEN_W-9:0], i_byte};
                    if (r_pos == bfhd_pkg::POS_LEN_END && r_err == bfhd_pkg::ST_OK
                        && n_len > i_cfg.max_payload_length)
                        n_err = bfhd_pkg::ST_LENGTH;
                end
            endcase
            n_pos = r_pos + 1'b1;
        end else if (r_err == bfhd_pkg::ST_OK && r_seen < {1'b0, r_len}) begin
            pass   = 1'b1;
            n_seen = r_seen + 1'b1;
        end

        // End-of-buffer status, in precedence order
        if (n_pos < bfhd_pkg::POS_DONE)
            code = bfhd_pkg::ST_SHORT;
        else if (n_err != bfhd_pkg::ST_OK)
            code = n_err;
        else if (n_seen < {1'b0, n_len})
            code = bfhd_pkg::ST_SHORT;
        else
            code = bfhd_pkg::ST_OK;

        pay.out_byte       = i_byte;
        pay.is_status      = 1'b0;
        pay.status_code    = bfhd_pkg::ST_OK;
        pay.message_type   = n_type;
        pay.payload_length = n_len;
        pay.run_last       = !i_eob;

        sts.out_byte       = 8'd0;
        sts.is_status      = 1'b1;
        sts.status_code    = code;
        sts.message_type   = n_type;
        sts.payload_length = (code == bfhd_pkg::ST_OK) ? n_len : '0;
        sts.run_last       = 1'b1;

        o_res0 = pass ? pay : sts;
        o_res1 = sts;
        o_nres = {1'b0, pass} + {1'b0, i_eob};

        // Clear for the next buffer
        if (i_eob) begin
            n_pos  = '0;
            n_len  = '0;
            n_type = '0;
            n_err  = bfhd_pkg::ST_OK;
            n_seen = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_len  <= '0;
            r_type <= '0;
            r_err  <= bfhd_pkg::ST_OK;
            r_seen <= '0;
        end else if (i_step) begin
            r_pos  <= n_pos;
            r_len  <= n_len;
            r_type <= n_type;
            r_err  <= n_err;
            r_seen <= n_seen;
        end
    end

endmodule

>>> hw/rtl/binary_frame_header_decoder.sv
// ============================================================================
// binary_frame_header_decoder
// Checks the 8-byte header of a received buffer (magic, version, type,
// big-endian length), passes payload bytes on and reports one status per
// buffer.
// ============================================================================
// Usage:
//   Input channel (i_valid / o_stall) carries one buffer byte per item with
//   an end-of-buffer flag. Output channel (o_valid / i_stall) carries result
//   items: a payload byte (o_is_status = 0) or the end-of-buffer status
//   (o_is_status = 1). o_run_last marks the last result caused by an item.
//   Header bytes and trailing bytes past the payload length give no result
//   unless they end the buffer.
//   Path: an item is held in the input register until the result stage is
//   free, then its results land in the two-entry result stage, whose slot 0
//   drives the output.
//   Throughput: one item per cycle while each item gives at most one result
//   and i_stall stays low; an item that gives a payload byte and a status
//   holds the result stage until the single output port has drained both.
//   Stall: when i_stall holds the output, the input register still takes one
//   more item, then o_stall rises until the result stage drains.
//   Reset (synchronous, i_rst_n low) clears frame state and both stages and
//   loads the register defaults (magic 'H','X', version 1, max length 65536).
//   Write registers over the APB port only while the block is idle.
// ============================================================================
module binary_frame_header_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input byte channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_buffer,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_is_status,
    output logic [2:0]  o_status_code,
    output logic [7:0]  o_message_type,
    output logic [31:0] o_payload_length,
    output logic        o_run_last,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ---------------------------------------------------------------- registers
    bfhd_pkg::t_cfg r_cfg;
    logic           cfg_we;
    logic [1:0]     cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.magic_first        <= 8'd72;
            r_cfg.magic_second       <= 8'd88;
            r_cfg.expected_version   <= 8'd1;
            r_cfg.max_payload_length <= 32'd65536;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                bfhd_pkg::REG_MAGIC_FIRST:  r_cfg.magic_first        <= pwdata[7:0];
                bfhd_pkg::REG_MAGIC_SECOND: r_cfg.magic_second       <= pwdata[7:0];
                bfhd_pkg::REG_VERSION:      r_cfg.expected_version   <= pwdata[7:0];
                bfhd_pkg::REG_MAX_LENGTH:   r_cfg.max_payload_length <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            bfhd_pkg::REG_MAGIC_FIRST:  prdata = {24'd0, r_cfg.magic_first};
            bfhd_pkg::REG_MAGIC_SECOND: prdata = {24'd0, r_cfg.magic_second};
            bfhd_pkg::REG_VERSION:      prdata = {24'd0, r_cfg.expected_version};
            bfhd_pkg::REG_MAX_LENGTH:   prdata = r_cfg.max_payload_length;
            default:                    prdata = '0;
        endcase
    end

    // ---------------------------------------------------------- handshake
    logic [1:0] r_cnt;      // results held in the result stage
    logic       take;       // result handed over this cycle
    logic       free;       // result stage empty after this cycle
    logic       advance;    // input register moves into the result stage
    logic       in_acc;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eob;

    assign o_valid = (r_cnt != 2'd0);
    assign take    = o_valid && !i_stall;
    assign free    = (r_cnt == 2'd0) || (r_cnt == 2'd1 && take);
    assign advance = r_in_valid && free;
    assign o_stall = r_in_valid && !free;
    assign in_acc  = i_valid && !o_stall;

    // Input register: hold while the result stage is busy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_byte <= i_data_byte;
            r_in_eob  <= i_end_of_buffer;
        end
    end

    // ---------------------------------------------------------- decode step
    bfhd_pkg::t_result res0, res1;
    logic [1:0]        nres;

    bfhd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_byte  (r_in_byte),
        .i_eob   (r_in_eob),
        .i_cfg   (r_cfg),
        .o_res0  (res0),
        .o_res1  (res1),
        .o_nres  (nres)
    );

    // ---------------------------------------------------------- result stage
    // Slot 0 drives the port; slot 1 holds the status behind a payload byte.
    bfhd_pkg::t_result r_res0, r_res1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (advance) begin
            r_cnt <= nres;
        end else if (take) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res0 <= res0;
            r_res1 <= res1;
        end else if (take && r_cnt == 2'd2) begin
            r_res0 <= r_res1;
        end
    end

    assign o_out_byte       = r_res0.out_byte;
    assign o_is_status      = r_res0.is_status;
    assign o_status_code    = r_res0.status_code;
    assign o_message_type   = r_res0.message_type;
    assign o_payload_length = r_res0.payload_length;
    assign o_run_last       = r_res0.run_last;

endmodule

>>> tb/binary_frame_header_decoder_checker.sv
// ============================================================================
// binary_frame_header_decoder_checker
// Watches the byte, result and register channels of the frame header
// decoder, predicts every result item from its own copy of the frame state
// and register settings, and compares each accepted result field by field.
// ============================================================================
module binary_frame_header_decoder_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte channel
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_buffer,
    // result channel
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_out_byte,
    input  logic        i_is_status,
    input  logic [2:0]  i_status_code,
    input  logic [7:0]  i_message_type,
    input  logic [31:0] i_payload_length,
    input  logic        i_run_last,
    // register port
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    // summary
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam bfhd_pkg::t_cfg CFG_DEFAULT = '{
        magic_first:        8'h48,
        magic_second:       8'h58,
        expected_version:   8'h01,
        max_payload_length: 32'd65536
    };

    bfhd_pkg::t_cfg              cfg_shadow;
    logic [bfhd_pkg::POS_W-1:0]  hdr_pos;
    logic [bfhd_pkg::LEN_W-1:0]  len_acc;
    logic [7:0]                  type_seen;
    bfhd_pkg::t_status           hdr_err;
    logic [bfhd_pkg::SEEN_W-1:0] payload_sent;

    bfhd_pkg::t_result expected_results[$];
    int                fail_total    = 0;
    int                checked_total = 0;

    task automatic report_mismatch(input string what);
        fail_total++;
        $display("MISMATCH @%0t: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want, input int idx);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
                                      idx, name, got, want));
    endtask

    task automatic clear_frame();
        hdr_pos      = '0;
        len_acc      = '0;
        type_seen    = '0;
        hdr_err      = bfhd_pkg::ST_OK;
        payload_sent = '0;
    endtask

    // Advance the frame state by one byte and queue the results it causes.
    task automatic decode_byte(input logic [7:0] value, input logic eob);
        bfhd_pkg::t_result produced [2];
        int                n;
        bfhd_pkg::t_status code;
        n = 0;
        if (hdr_pos < bfhd_pkg::POS_DONE) begin
            case (hdr_pos)
                bfhd_pkg::POS_MAGIC0: begin
                    if (value != cfg_shadow.magic_first && hdr_err == bfhd_pkg::ST_OK)
                        hdr_err = bfhd_pkg::ST_MAGIC;
                end
                bfhd_pkg::POS_MAGIC1: begin
                    if (value != cfg_shadow.magic_second && hdr_err == bfhd_pkg::ST_OK)
                        hdr_err = bfhd_pkg::ST_MAGIC;
                end
                bfhd_pkg::POS_VERSION: begin
                    if (value != cfg_shadow.expected_version &&
                        hdr_err == bfhd_pkg::ST_OK)
                        hdr_err = bfhd_pkg::ST_VERSION;
                end
                bfhd_pkg::POS_TYPE: begin
                    // latch the type even when it is out of range
                    type_seen = value;
                    if ((value < bfhd_pkg::TYPE_MIN || value > bfhd_pkg::TYPE_MAX) &&
                        hdr_err == bfhd_pkg::ST_OK)
                        hdr_err = bfhd_pkg::ST_TYPE;
                end
                default: begin
                    len_acc = {len_acc[bfhd_pkg::LEN_W-9:0], value};
                    if (hdr_pos == bfhd_pkg::POS_LEN_END && hdr_err == bfhd_pkg::ST_OK &&
                        len_acc > cfg_shadow.max_payload_length)
                        hdr_err = bfhd_pkg::ST_LENGTH;
                end
            endcase
            hdr_pos = hdr_pos + 1'b1;
        end else if (hdr_err == bfhd_pkg::ST_OK && payload_sent < {1'b0, len_acc}) begin
            produced[n] = '{out_byte: value, is_status: 1'b0,
                            status_code: bfhd_pkg::ST_OK,
                            message_type: type_seen, payload_length: len_acc,
                            run_last: 1'b0};
            n++;
            payload_sent = payload_sent + 1'b1;
        end

        if (eob) begin
            if (hdr_pos < bfhd_pkg::POS_DONE)
                code = bfhd_pkg::ST_SHORT;
            else if (hdr_err != bfhd_pkg::ST_OK)
                code = hdr_err;
            else if (payload_sent < {1'b0, len_acc})
                code = bfhd_pkg::ST_SHORT;
            else
                code = bfhd_pkg::ST_OK;
            produced[n] = '{out_byte: 8'h00, is_status: 1'b1, status_code: code,
                            message_type: type_seen,
                            payload_length: (code == bfhd_pkg::ST_OK) ? len_acc : '0,
                            run_last: 1'b0};
            n++;
            clear_frame();
        end

        if (n > 0)
            produced[n-1].run_last = 1'b1;
        for (int k = 0; k < n; k++)
            expected_results.push_back(produced[k]);
    endtask

    task automatic check_result();
        bfhd_pkg::t_result want;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result: byte 0x%0h status %0b code %0d",
                                      i_out_byte, i_is_status, i_status_code));
        end else begin
            want = expected_results.pop_front();
            check_field("out_byte",       32'(i_out_byte),       32'(want.out_byte),
                        checked_total);
            check_field("is_status",      32'(i_is_status),      32'(want.is_status),
                        checked_total);
            check_field("status_code",    32'(i_status_code),    32'(want.status_code),
                        checked_total);
            check_field("message_type",   32'(i_message_type),   32'(want.message_type),
                        checked_total);
            check_field("payload_length", i_payload_length,      want.payload_length,
                        checked_total);
            check_field("run_last",       32'(i_run_last),       32'(want.run_last),
                        checked_total);
            checked_total++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_shadow = CFG_DEFAULT;
            clear_frame();
            expected_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    bfhd_pkg::REG_MAGIC_FIRST:
                        cfg_shadow.magic_first        = i_pwdata[7:0];
                    bfhd_pkg::REG_MAGIC_SECOND:
                        cfg_shadow.magic_second       = i_pwdata[7:0];
                    bfhd_pkg::REG_VERSION:
                        cfg_shadow.expected_version   = i_pwdata[7:0];
                    bfhd_pkg::REG_MAX_LENGTH:
                        cfg_shadow.max_payload_length = i_pwdata;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                decode_byte(i_data_byte, i_end_of_buffer);
            if (i_out_valid && !i_out_stall)
                check_result();
        end
        o_pending      <= expected_results.size();
        o_fail_count   <= fail_total;
        o_result_count <= checked_total;
    end

endmodule

>>> tb/binary_frame_header_decoder_tb.sv
// ============================================================================
// binary_frame_header_decoder_tb
// Drives received buffers byte by byte into the frame header decoder under
// five register settings: a short directed set of frames, then random
// buffers that are mostly well-formed frames with corrupted fields, cut
// buffers, trailing bytes and noise. Both channels idle at random. The
// checker beside the block predicts and compares every result.
// ============================================================================
module binary_frame_header_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles to let pass after the last expected result: an item that gives
    // no result may still sit in the two-stage pipeline.
    localparam int SETTLE_CYCLES = 6;

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_valid         = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte     = 8'h00;
    logic        i_end_of_buffer = 1'b0;
    logic        o_valid;
    logic        i_stall         = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_is_status;
    logic [2:0]  o_status_code;
    logic [7:0]  o_message_type;
    logic [31:0] o_payload_length;
    logic        o_run_last;
    logic        psel            = 1'b0;
    logic        penable         = 1'b0;
    logic        pwrite          = 1'b0;
    logic [3:0]  paddr           = 4'h0;
    logic [31:0] pwdata          = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending_results;
    int results_checked;

    // Register settings as the stimulus sees them, used to build good frames
    logic [7:0]  cfg_m0  = 8'h48;
    logic [7:0]  cfg_m1  = 8'h58;
    logic [7:0]  cfg_ver = 8'h01;
    logic [31:0] cfg_max = 32'd65536;

    logic        quiet_run = 1'b0;   // no idling on either side while set
    logic [7:0]  frame_bytes[$];
    int          bytes_sent   = 0;
    int          buffers_sent = 0;

    binary_frame_header_decoder dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .i_end_of_buffer  (i_end_of_buffer),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_out_byte       (o_out_byte),
        .o_is_status      (o_is_status),
        .o_status_code    (o_status_code),
        .o_message_type   (o_message_type),
        .o_payload_length (o_payload_length),
        .o_run_last       (o_run_last),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    binary_frame_header_decoder_checker checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_data_byte      (i_data_byte),
        .i_end_of_buffer  (i_end_of_buffer),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_out_byte       (o_out_byte),
        .i_is_status      (o_is_status),
        .i_status_code    (o_status_code),
        .i_message_type   (o_message_type),
        .i_payload_length (o_payload_length),
        .i_run_last       (o_run_last),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_pready         (pready),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .o_fail_count     (fail_count),
        .o_pending        (pending_results),
        .o_result_count   (results_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side: stall at random, about 31 percent of the time, never during a
    // quiet run.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_stall <= 1'b0;
        else
            i_stall <= !quiet_run && ($urandom_range(0, 99) < 31);
    end

    // Offer one byte, idling first at random; return once it is accepted.
    // Valid stays high into the next call, which either lowers it or puts up
    // the next byte, so each step sees a single assignment to it.
    task automatic send_byte(input logic [7:0] value, input logic eob);
        while (!quiet_run && $urandom_range(0, 99) < 31) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_data_byte     <= value;
        i_end_of_buffer <= eob;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        bytes_sent++;
    endtask

    // Send the staged buffer, marking its last byte as the end of buffer.
    task automatic send_buffer();
        foreach (frame_bytes[k])
            send_byte(frame_bytes[k], k == frame_bytes.size() - 1);
        buffers_sent++;
        frame_bytes.delete();
    endtask

    task automatic push_header(input logic [7:0] m0, input logic [7:0] m1,
                               input logic [7:0] ver, input logic [7:0] msg_type,
                               input logic [31:0] len);
        frame_bytes.push_back(m0);
        frame_bytes.push_back(m1);
        frame_bytes.push_back(ver);
        frame_bytes.push_back(msg_type);
        frame_bytes.push_back(len[31:24]);
        frame_bytes.push_back(len[23:16]);
        frame_bytes.push_back(len[15:8]);
        frame_bytes.push_back(len[7:0]);
    endtask

    // Hold the sender until every expected result is back, then let the
    // pipeline empty. The first edge lets the checker see the last item.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Setup and access cycle, then an idle cycle so back-to-back writes
    // never drive the bus twice in one step.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write all four registers; call only with the block drained.
    task automatic set_config(input logic [7:0] m0, input logic [7:0] m1,
                              input logic [7:0] ver, input logic [31:0] max_len);
        write_reg(bfhd_pkg::REG_MAGIC_FIRST, {24'h0, m0});
        write_reg(bfhd_pkg::REG_MAGIC_SECOND, {24'h0, m1});
        write_reg(bfhd_pkg::REG_VERSION, {24'h0, ver});
        write_reg(bfhd_pkg::REG_MAX_LENGTH, max_len);
        cfg_m0  = m0;
        cfg_m1  = m1;
        cfg_ver = ver;
        cfg_max = max_len;
    endtask

    // Build and send one random buffer. Most are frames with a good header
    // and random payload; some get one header field corrupted, a cut, or
    // trailing bytes; the rest are short runs of noise.
    task automatic send_random_buffer();
        logic [7:0]  m0, m1, ver, msg_type;
        logic [31:0] len;
        int          n_payload;
        int          keep;
        if ($urandom_range(0, 99) < 12) begin
            repeat ($urandom_range(1, 10))
                frame_bytes.push_back(8'($urandom));
        end else begin
            m0       = cfg_m0;
            m1       = cfg_m1;
            ver      = cfg_ver;
            msg_type = 8'($urandom_range(bfhd_pkg::TYPE_MIN, bfhd_pkg::TYPE_MAX));
            // mostly short payloads; now and then a wide length to toggle
            // every bit of the length field
            if ($urandom_range(0, 9) == 0)
                len = $urandom;
            else
                len = $urandom_range(0, (cfg_max < 12) ? cfg_max : 12);
            if ($urandom_range(0, 99) < 25) begin
                case ($urandom_range(0, 4))
                    0: m0 = m0 ^ 8'($urandom_range(1, 255));
                    1: m1 = m1 ^ 8'($urandom_range(1, 255));
                    2: ver = ver ^ 8'($urandom_range(1, 255));
                    3: msg_type = $urandom_range(0, 1) ? 8'h00
                                                       : 8'($urandom_range(9, 255));
                    default: len = (cfg_max == 32'hFFFF_FFFF) ? cfg_max : cfg_max + 1;
                endcase
            end
            push_header(m0, m1, ver, msg_type, len);
            n_payload = (len <= 40) ? int'(len) : $urandom_range(0, 20);
            repeat (n_payload)
                frame_bytes.push_back(8'($urandom));
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3))
                    frame_bytes.push_back(8'($urandom));
            end
            // cut the buffer anywhere, down to a single byte
            if ($urandom_range(0, 99) < 15) begin
                keep = $urandom_range(1, frame_bytes.size());
                while (frame_bytes.size() > keep)
                    void'(frame_bytes.pop_back());
            end
        end
        send_buffer();
    endtask

    task automatic run_random(input int n_bytes);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes)
            send_random_buffer();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- Directed frames under the reset settings ---
        // Good frame, top type, one payload byte of all ones, then a trailing
        // byte that carries the end of buffer.
        push_header(cfg_m0, cfg_m1, cfg_ver, bfhd_pkg::TYPE_MAX, 32'd1);
        frame_bytes.push_back(8'hFF);
        frame_bytes.push_back(8'h00);
        send_buffer();
        // A lone byte: header too short.
        frame_bytes.push_back(8'h00);
        send_buffer();
        // Bad magic, out-of-range type and an oversized length: the type is
        // still latched, the length check is skipped, no payload is passed.
        push_header(8'h00, cfg_m1, cfg_ver, bfhd_pkg::TYPE_MAX + 8'd1, 32'hFFFF_FFFF);
        frame_bytes.push_back(8'hFF);
        send_buffer();
        // Length one above the maximum, ending on the last header byte.
        push_header(cfg_m0, cfg_m1, cfg_ver, bfhd_pkg::TYPE_MIN, 32'd65537);
        send_buffer();

        // --- Random buffers over several register settings ---
        run_random(300);
        drain();

        set_config(8'h00, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        run_random(150);
        // hold off the sender until every result is back
        drain();
        run_random(150);
        drain();

        // Zero maximum length; no idling on either side for the whole phase.
        set_config(8'hFF, 8'h00, 8'h00, 32'h0);
        quiet_run <= 1'b1;
        run_random(350);
        drain();
        quiet_run <= 1'b0;

        set_config(8'($urandom), 8'($urandom), 8'($urandom), $urandom_range(1, 24));
        run_random(400);
        drain();

        set_config(8'($urandom), 8'($urandom), 8'($urandom), $urandom);
        run_random(400);
        drain();

        $display("Covered %0d buffers (%0d bytes) under five register settings.",
                 buffers_sent, bytes_sent);
        $display("Compared %0d result items, %0d mismatches.",
                 results_checked, fail_count);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Stop a hung run well after the slowest correct one would have ended.
    initial begin
        #10ms;
        $display("Timeout: results still outstanding or sender blocked");
        $display("Some tests failed");
        $finish;
    end

endmodule
